// ===== rtl/snps_pkg.sv =====
// shared types and constants for the soil nitrogen pool step
`timescale 1ns / 1ps
package snps_pkg;

  localparam int unsigned PoolW = 32;
  localparam int unsigned FracW = 17;
  localparam int unsigned RunoffW = 24;
  localparam int unsigned SensW = 16;
  localparam int unsigned ExpLast = 24;
  localparam int unsigned AddrW = 5;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_TRANSFER = 2'd2
  } err_code_e;

  typedef enum logic [2:0] {
    REG_INIT_LITTER  = 3'd0,
    REG_INIT_FAST    = 3'd1,
    REG_INIT_SLOW    = 3'd2,
    REG_INIT_MINERAL = 3'd3,
    REG_LEACH_SENS   = 3'd4
  } reg_idx_e;

  // datapath micro-operations issued by the controller, in issue order
  typedef enum logic [3:0] {
    OP_CHECK    = 4'd0,
    OP_DIV_L    = 4'd1,
    OP_MUL_L    = 4'd2,
    OP_DIV_F    = 4'd3,
    OP_MUL_F    = 4'd4,
    OP_DIV_S    = 4'd5,
    OP_MUL_S    = 4'd6,
    OP_DIV_TF   = 4'd7,
    OP_MUL_TF   = 4'd8,
    OP_DIV_TS   = 4'd9,
    OP_MUL_TS   = 4'd10,
    OP_SUMS     = 4'd11,
    OP_EXP      = 4'd12,
    OP_LEACH    = 4'd13,
    OP_COMMIT   = 4'd14
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic err;
  } dp_sts_t;

  typedef struct packed {
    logic [PoolW-1:0] litter_carbon;
    logic [PoolW-1:0] fast_carbon;
    logic [PoolW-1:0] slow_carbon;
    logic [PoolW-1:0] litter_carbon_lost;
    logic [PoolW-1:0] fast_carbon_lost;
    logic [PoolW-1:0] slow_carbon_lost;
    logic [PoolW-1:0] carbon_into_fast;
    logic [PoolW-1:0] carbon_into_slow;
    logic [RunoffW-1:0] runoff_depth;
  } in_item_t;

  typedef struct packed {
    logic [PoolW-1:0] litter_n_out;
    logic [PoolW-1:0] fast_n_out;
    logic [PoolW-1:0] slow_n_out;
    logic [PoolW-1:0] mineral_n_out;
    logic [PoolW-1:0] litter_n_released;
    logic [PoolW-1:0] fast_n_released;
    logic [PoolW-1:0] slow_n_released;
    logic [PoolW-1:0] n_into_fast;
    logic [PoolW-1:0] n_into_slow;
    logic [PoolW-1:0] n_mineralized;
    logic [PoolW-1:0] n_leached;
    logic [1:0]       error_code;
  } out_item_t;

  function automatic logic [FracW-1:0] exp_lut(input logic [4:0] idx);
    logic [FracW-1:0] v;
    case (idx)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd39749;
      5'd2: v = 17'd24109;
      5'd3: v = 17'd14623;
      5'd4: v = 17'd8869;
      5'd5: v = 17'd5380;
      5'd6: v = 17'd3263;
      5'd7: v = 17'd1979;
      5'd8: v = 17'd1200;
      5'd9: v = 17'd728;
      5'd10: v = 17'd442;
      5'd11: v = 17'd268;
      5'd12: v = 17'd162;
      5'd13: v = 17'd99;
      5'd14: v = 17'd60;
      5'd15: v = 17'd36;
      5'd16: v = 17'd22;
      5'd17: v = 17'd13;
      5'd18: v = 17'd8;
      5'd19: v = 17'd5;
      5'd20: v = 17'd3;
      5'd21: v = 17'd2;
      5'd22: v = 17'd1;
      5'd23: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/snps_stream_if.sv =====
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
interface snps_in_if
  import snps_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface snps_out_if
  import snps_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/snps_datapath.sv =====
// pool registers, shared divider and multiplier, leaching interpolation
`timescale 1ns / 1ps
module snps_datapath
  import snps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  in_item_t         item_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [3:0]       pool_wr_i,
  input  logic [PoolW-1:0] pool_wdata_i,
  input  logic [SensW-1:0] sens_i,
  output out_item_t        res_o
);

  localparam int unsigned DivCntW = 6;
  localparam int unsigned MulCntW = 6;

  in_item_t item_q;
  logic [PoolW-1:0] lit_q, fst_q, slw_q, min_q;
  logic [PoolW-1:0] rl_q, rf_q, rs_q, nf_q, ns_q, mz_q, lch_q, mb_q;
  logic [FracW-1:0] frac_q, efrac_q;
  logic             err_flag_q;
  logic [1:0]       err_q;

  // restoring divider: (num << 16) / den, quotient up to 17 bits
  logic [48:0]        div_rem_q;
  logic [PoolW-1:0]   div_den_q;
  logic [FracW-1:0]   div_quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_busy_q;
  logic [48:0]        div_num_q;

  // shift-add multiplier: a (up to 33 bits) * b (17 bits)
  logic [49:0]        mul_acc_q;
  logic [32:0]        mul_a_q;
  logic [FracW-1:0]   mul_b_q;
  logic [MulCntW-1:0] mul_cnt_q;
  logic               mul_busy_q;

  logic               cmd_busy_q;
  op_e                op_q;

  logic [39:0] x_w;
  logic [4:0]  xi_w;
  logic        x_big_w;
  logic [FracW-1:0] ea_w, eb_w;

  assign x_w     = 40'(sens_i) * 40'(item_q.runoff_depth);
  assign x_big_w = (x_w[39:23] >= 17'(ExpLast));
  assign xi_w    = x_w[27:23];
  assign ea_w    = exp_lut(xi_w);
  assign eb_w    = exp_lut(5'(xi_w + 5'd1));

  logic [PoolW-1:0] div_num_sel, div_den_sel;
  logic [32:0]      mul_a_sel;
  logic [FracW-1:0] mul_b_sel;
  logic             use_div, use_mul;

  // empty or fully lost pool and zero decomposition override the quotient
  always_comb begin
    div_num_sel = '0;
    div_den_sel = 32'd1;
    mul_a_sel   = '0;
    mul_b_sel   = '0;
    use_div     = 1'b0;
    use_mul     = 1'b0;
    case (cmd_i.op)
      OP_DIV_L: begin
        use_div = 1'b1; div_num_sel = item_q.litter_carbon_lost;
        div_den_sel = item_q.litter_carbon;
      end
      OP_DIV_F: begin
        use_div = 1'b1; div_num_sel = item_q.fast_carbon_lost;
        div_den_sel = item_q.fast_carbon;
      end
      OP_DIV_S: begin
        use_div = 1'b1; div_num_sel = item_q.slow_carbon_lost;
        div_den_sel = item_q.slow_carbon;
      end
      OP_DIV_TF: begin
        use_div = 1'b1; div_num_sel = item_q.carbon_into_fast;
        div_den_sel = item_q.litter_carbon_lost;
      end
      OP_DIV_TS: begin
        use_div = 1'b1; div_num_sel = item_q.carbon_into_slow;
        div_den_sel = item_q.fast_carbon_lost;
      end
      OP_MUL_L: begin
        use_mul = 1'b1; mul_a_sel = {1'b0, lit_q};
        mul_b_sel = (item_q.litter_carbon_lost < item_q.litter_carbon) ? frac_q :
                    (item_q.litter_carbon == '0) ? 17'd0 : 17'd65536;
      end
      OP_MUL_F: begin
        use_mul = 1'b1; mul_a_sel = {1'b0, fst_q};
        mul_b_sel = (item_q.fast_carbon_lost < item_q.fast_carbon) ? frac_q :
                    (item_q.fast_carbon == '0) ? 17'd0 : 17'd65536;
      end
      OP_MUL_S: begin
        use_mul = 1'b1; mul_a_sel = {1'b0, slw_q};
        mul_b_sel = (item_q.slow_carbon_lost < item_q.slow_carbon) ? frac_q :
                    (item_q.slow_carbon == '0) ? 17'd0 : 17'd65536;
      end
      OP_MUL_TF: begin
        use_mul = 1'b1; mul_a_sel = {1'b0, rl_q};
        mul_b_sel = (item_q.litter_carbon_lost == '0) ? 17'd0 : frac_q;
      end
      OP_MUL_TS: begin
        use_mul = 1'b1; mul_a_sel = {1'b0, rf_q};
        mul_b_sel = (item_q.fast_carbon_lost == '0) ? 17'd0 : frac_q;
      end
      OP_EXP: begin
        use_mul = 1'b1; mul_a_sel = 33'(ea_w - eb_w); mul_b_sel = {1'b0, x_w[22:7]};
      end
      OP_LEACH: begin use_mul = 1'b1; mul_a_sel = {1'b0, mb_q}; mul_b_sel = efrac_q; end
      default: ;
    endcase
  end

  logic [49:0] div_trial;
  logic [33:0] sum_m;
  logic [32:0] sum_f, sum_s, sum_mb;
  logic [PoolW-1:0] sat_f, sat_s, sat_m, sat_mb;
  logic [PoolW-1:0] mul_hi;

  assign div_trial = {1'b0, div_rem_q[47:0], div_num_q[48]} - {18'd0, div_den_q};
  assign mul_hi = mul_acc_q[47:16];
  assign sum_m  = 34'(rl_q - nf_q) + 34'(rf_q - ns_q) + 34'(rs_q);
  assign sat_m  = (sum_m > 34'hFFFFFFFF) ? '1 : sum_m[31:0];
  assign sum_f  = 33'(fst_q - rf_q) + 33'(nf_q);
  assign sat_f  = sum_f[32] ? '1 : sum_f[31:0];
  assign sum_s  = 33'(slw_q - rs_q) + 33'(ns_q);
  assign sat_s  = sum_s[32] ? '1 : sum_s[31:0];
  assign sum_mb = 33'(min_q) + 33'(sat_m);
  assign sat_mb = sum_mb[32] ? '1 : sum_mb[31:0];

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q      <= '0;
      fst_q      <= '0;
      slw_q      <= '0;
      min_q      <= '0;
      div_busy_q <= 1'b0;
      mul_busy_q <= 1'b0;
      cmd_busy_q <= 1'b0;
      op_q       <= OP_CHECK;
      done_q     <= 1'b0;
      err_flag_q <= 1'b0;
      err_q      <= ERR_NONE;
    end else begin
      done_q <= 1'b0;
      if (pool_wr_i[0]) lit_q <= pool_wdata_i;
      if (pool_wr_i[1]) fst_q <= pool_wdata_i;
      if (pool_wr_i[2]) slw_q <= pool_wdata_i;
      if (pool_wr_i[3]) min_q <= pool_wdata_i;
      if (cmd_i.start) begin
        op_q <= cmd_i.op;
        if (use_div) begin
          div_busy_q <= 1'b1;
          div_num_q  <= {1'b0, div_num_sel, 16'd0};
          div_den_q  <= div_den_sel;
          div_rem_q  <= '0;
          div_quo_q  <= '0;
          div_cnt_q  <= DivCntW'(49);
        end else if (use_mul) begin
          mul_busy_q <= 1'b1;
          mul_a_q    <= mul_a_sel;
          mul_b_q    <= mul_b_sel;
          mul_acc_q  <= '0;
          mul_cnt_q  <= MulCntW'(FracW);
        end else begin
          done_q <= 1'b1;
          case (cmd_i.op)
            OP_CHECK: begin
              if ((item_q.litter_carbon == 0 && item_q.litter_carbon_lost != 0) ||
                  (item_q.fast_carbon == 0 && item_q.fast_carbon_lost != 0) ||
                  (item_q.slow_carbon == 0 && item_q.slow_carbon_lost != 0)) begin
                err_flag_q <= 1'b1; err_q <= ERR_EMPTY;
              end else if ((item_q.litter_carbon_lost != 0 &&
                            item_q.carbon_into_fast > item_q.litter_carbon_lost) ||
                           (item_q.fast_carbon_lost != 0 &&
                            item_q.carbon_into_slow > item_q.fast_carbon_lost)) begin
                err_flag_q <= 1'b1; err_q <= ERR_TRANSFER;
              end else begin
                err_flag_q <= 1'b0; err_q <= ERR_NONE;
              end
              rl_q <= '0; rf_q <= '0; rs_q <= '0; nf_q <= '0; ns_q <= '0;
              mz_q <= '0; lch_q <= '0;
            end
            OP_SUMS: begin
              mz_q <= sat_m;
              mb_q <= sat_mb;
            end
            OP_COMMIT: begin
              lit_q <= lit_q - rl_q;
              fst_q <= sat_f;
              slw_q <= sat_s;
              min_q <= mb_q - lch_q;
            end
            default: ;
          endcase
        end
      end else if (div_busy_q) begin
        div_num_q <= {div_num_q[47:0], 1'b0};
        if (!div_trial[49]) begin
          div_rem_q <= div_trial[48:0];
        end else begin
          div_rem_q <= {div_rem_q[47:0], div_num_q[48]};
        end
        div_quo_q <= {div_quo_q[FracW-2:0], ~div_trial[49]};
        div_cnt_q <= div_cnt_q - 1'b1;
        if (div_cnt_q == 1) begin
          div_busy_q <= 1'b0;
          done_q     <= 1'b1;
        end
      end else if (mul_busy_q) begin
        if (mul_b_q[FracW-1]) mul_acc_q <= {mul_acc_q[48:0], 1'b0} + 50'(mul_a_q);
        else mul_acc_q <= {mul_acc_q[48:0], 1'b0};
        mul_b_q   <= {mul_b_q[FracW-2:0], 1'b0};
        mul_cnt_q <= mul_cnt_q - 1'b1;
        if (mul_cnt_q == 1) begin
          mul_busy_q <= 1'b0;
          cmd_busy_q <= 1'b1;
        end
      end else if (cmd_busy_q) begin
        cmd_busy_q <= 1'b0;
        done_q     <= 1'b1;
        case (op_q)
          OP_MUL_L:  rl_q <= mul_hi;
          OP_MUL_F:  rf_q <= mul_hi;
          OP_MUL_S:  rs_q <= mul_hi;
          OP_MUL_TF: nf_q <= mul_hi;
          OP_MUL_TS: ns_q <= mul_hi;
          OP_EXP:    efrac_q <= x_big_w ? 17'd65536 :
                                17'(17'd65536 - (ea_w - mul_acc_q[32:16]));
          OP_LEACH:  lch_q <= mul_hi;
          default: ;
        endcase
      end
      // quotient of the finished division
      if (div_busy_q && div_cnt_q == 1) begin
        frac_q <= {div_quo_q[FracW-2:0], ~div_trial[49]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) item_q <= item_i;
  end

  assign sts_o.done = done_q;
  assign sts_o.err  = err_flag_q;

  assign res_o.litter_n_out      = lit_q;
  assign res_o.fast_n_out        = fst_q;
  assign res_o.slow_n_out        = slw_q;
  assign res_o.mineral_n_out     = min_q;
  assign res_o.litter_n_released = rl_q;
  assign res_o.fast_n_released   = rf_q;
  assign res_o.slow_n_released   = rs_q;
  assign res_o.n_into_fast       = nf_q;
  assign res_o.n_into_slow       = ns_q;
  assign res_o.n_mineralized     = mz_q;
  assign res_o.n_leached         = lch_q;
  assign res_o.error_code        = err_q;

endmodule

// ===== rtl/snps_ctrl.sv =====
// sequencer that walks the datapath through one time step
`timescale 1ns / 1ps
module snps_ctrl
  import snps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i,
  output logic    capture_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;

  // output register frees the datapath once captured
  assign in_ready_o  = (state_q == ST_IDLE);
  assign load_o      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.start = 1'b0;
    cmd_o.op    = op_q;
    capture_o   = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = ST_ISSUE;
        op_d    = OP_CHECK;
      end
      ST_ISSUE: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: if (sts_i.done) begin
        if (op_q == OP_COMMIT || (op_q == OP_CHECK && sts_i.err)) begin
          state_d = ST_OUT;
        end else begin
          op_d    = op_e'(op_q + 4'd1);
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: if (!out_valid_q || out_ready_i) begin
        capture_o   = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_CHECK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/soil_nitrogen_pool_step.sv =====
// top level: soil nitrogen pool step with apb configuration
// one input transaction at a time: a check, five serial divisions, seven shift-add
// products, the sum and commit steps and an output step on one shared divider and
// multiplier; a new item is taken only after its result is captured, and an error
// item goes from the check straight to the output
// reset clears control, loads pools to zero and leach sensitivity to 1.0
`timescale 1ns / 1ps
module soil_nitrogen_pool_step
  import snps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  snps_in_if.sink           in_if,
  snps_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [PoolW-1:0] init_q [4];
  logic [SensW-1:0] sens_q;
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic [3:0]       pool_wr;
  logic             load, capture;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  out_item_t        res, res_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign pool_wr = wr_en && reg_idx < 3'(REG_LEACH_SENS) && paddr[1:0] == 2'b00 ?
                   4'(4'b0001 << reg_idx[1:0]) : 4'b0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) init_q[i] <= '0;
      sens_q <= 16'd256;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_INIT_LITTER, REG_INIT_FAST, REG_INIT_SLOW, REG_INIT_MINERAL:
          init_q[reg_idx[1:0]] <= pwdata;
        REG_LEACH_SENS: sens_q <= pwdata[SensW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INIT_LITTER, REG_INIT_FAST, REG_INIT_SLOW, REG_INIT_MINERAL:
        prdata = init_q[reg_idx[1:0]];
      REG_LEACH_SENS: prdata = {16'd0, sens_q};
      default: prdata = '0;
    endcase
  end

  snps_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .load_o(load),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts), .capture_o(capture)
  );

  snps_datapath u_dp (
    .clk_i, .rst_ni, .load_i(load), .item_i(in_if.data),
    .cmd_i(cmd), .sts_o(sts), .pool_wr_i(pool_wr), .pool_wdata_i(pwdata),
    .sens_i(sens_q), .res_o(res)
  );

  always_ff @(posedge clk_i) begin
    if (capture) res_q <= res;
  end
  assign out_if.data = res_q;

endmodule

// ===== rtl/snps_checker.sv =====
// port-level checks for the soil nitrogen pool step, bound to the top level
`timescale 1ns / 1ps
module snps_checker
  import snps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.error_code != 2'd3)
    else $error("undefined error code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.error_code != ERR_NONE |->
      out_data.n_leached == 0 && out_data.n_mineralized == 0)
    else $error("flux on an error transaction");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind soil_nitrogen_pool_step snps_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
